@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the pixel address unit.
// Define NO_ASSERTIONS to compile the macros to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RDPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define RDPA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RDPA_ASSERT(label, clk, rst_n, prop, msg)
`define RDPA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ sv/rdpa_pkg.sv @@
// Package of the rotated digit pixel address unit: widths, register codes,
// reset values and the configuration struct. Depends on nothing.
`default_nettype none

package rdpa_pkg;

    // Default values of the top-level parameters.
    localparam int ROW_COUNT_DEF  = 64;
    localparam int COL_COUNT_DEF  = 32;
    localparam int SRC_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    // Field and datapath widths.
    localparam int TRIG_W      = 14;
    localparam int SHIFT_W     = 24;
    localparam int START_W     = 18;
    localparam int STEP_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 5;
    localparam int BASE_W      = 19;
    localparam int POS_W       = 24;
    localparam int PROD_W      = POS_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ACC_W       = 32;
    localparam int COORD_W     = 20;
    localparam int SRC_X_W     = 10;
    localparam int SRC_Y_W     = 9;
    localparam int LIMIT_W     = 9;
    localparam int POS_FRAC    = 8;
    localparam int TRIG_FRAC   = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COS      = 3'd0,
        REG_SIN      = 3'd1,
        REG_SHIFT_X  = 3'd2,
        REG_SHIFT_Y  = 3'd3,
        REG_START_Y  = 3'd4,
        REG_ROW_STEP = 3'd5,
        REG_COL_STEP = 3'd6
    } cfg_reg_t;

    localparam logic signed [TRIG_W-1:0]  COS_RESET      = 14'sd4096;
    localparam logic signed [TRIG_W-1:0]  SIN_RESET      = 14'sd0;
    localparam logic signed [SHIFT_W-1:0] SHIFT_X_RESET  = 24'sd0;
    localparam logic signed [SHIFT_W-1:0] SHIFT_Y_RESET  = 24'sd0;
    localparam logic [START_W-1:0]        START_Y_RESET  = 18'd0;
    localparam logic [STEP_W-1:0]         ROW_STEP_RESET = 16'd256;
    localparam logic [STEP_W-1:0]         COL_STEP_RESET = 16'd256;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_q12;
        logic signed [TRIG_W-1:0]  sin_q12;
        logic signed [SHIFT_W-1:0] shift_x_q12;
        logic signed [SHIFT_W-1:0] shift_y_q12;
        logic [START_W-1:0]        start_y_q8;
        logic [STEP_W-1:0]         row_step_q8;
        logic [STEP_W-1:0]         col_step_q8;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/rotated_digit_pixel_address_unit.sv @@
// Rotated digit pixel address unit: maps a destination pixel of a scaled,
// deskewed digit window to its nearest source image coordinate.
//
// Input channel (in_valid / in_stall) carries one word per pixel: row,
// column and the digit's Q8 x origin. Output channel (out_valid /
// out_stall) carries src_x, src_y and in_bounds; a pixel outside the
// window or the image gives in_bounds low and both coordinates zero.
// A word moves at a rising edge where valid is high and stall is low.
// The configuration port (cfg_write, cfg_index, cfg_data) writes one
// register per cycle; write it only while the pipeline is empty.
//
// The stages are destination position, rotation products, sums
// with the Q8 shift and translation, then Q12 shift and bounds check into
// the output register. It takes one word per cycle while out_stall is low.
// Each stage holds its word while the next is full, so empty stages fill
// up during an output stall; in_stall rises only when all four are full.
// Reset empties the pipeline and loads the registers with identity
// rotation, unit scale and zero offsets.
`default_nettype none
`include "assert_macros.svh"

module rotated_digit_pixel_address_unit #(
    parameter int ROW_COUNT  = rdpa_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT  = rdpa_pkg::COL_COUNT_DEF,
    parameter int SRC_WIDTH  = rdpa_pkg::SRC_WIDTH_DEF,
    parameter int IMG_HEIGHT = rdpa_pkg::IMG_HEIGHT_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [rdpa_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [rdpa_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [rdpa_pkg::ROW_W-1:0]             row,
    input  wire logic [rdpa_pkg::COL_W-1:0]             column,
    input  wire logic signed [rdpa_pkg::BASE_W-1:0]     digit_base_x_q8,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [rdpa_pkg::SRC_X_W-1:0]                src_x,
    output logic [rdpa_pkg::SRC_Y_W-1:0]                src_y,
    output logic                                        in_bounds
);

    rdpa_pkg::cfg_t                         cfg;
    logic                                   d_valid;
    logic                                   d_stall;
    logic signed [rdpa_pkg::POS_W-1:0]      d_dst_x;
    logic signed [rdpa_pkg::POS_W-1:0]      d_dst_y;
    logic                                   d_win_ok;
    logic                                   r_valid;
    logic                                   r_stall;
    logic signed [rdpa_pkg::ACC_W-1:0]      r_acc_x;
    logic signed [rdpa_pkg::ACC_W-1:0]      r_acc_y;
    logic                                   r_win_ok;

    rdpa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rdpa_dst #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_dst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .row             (row),
        .column          (column),
        .digit_base_x_q8 (digit_base_x_q8),
        .cfg             (cfg),
        .out_valid       (d_valid),
        .out_stall       (d_stall),
        .dst_x           (d_dst_x),
        .dst_y           (d_dst_y),
        .win_ok          (d_win_ok)
    );

    rdpa_rotate u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_stall   (d_stall),
        .dst_x      (d_dst_x),
        .dst_y      (d_dst_y),
        .win_ok     (d_win_ok),
        .cfg        (cfg),
        .out_valid  (r_valid),
        .out_stall  (r_stall),
        .acc_x      (r_acc_x),
        .acc_y      (r_acc_y),
        .out_win_ok (r_win_ok)
    );

    rdpa_bound #(
        .SRC_WIDTH  (SRC_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_bound (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_stall  (r_stall),
        .acc_x     (r_acc_x),
        .acc_y     (r_acc_y),
        .win_ok    (r_win_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .src_x     (src_x),
        .src_y     (src_y),
        .in_bounds (in_bounds)
    );

    // The input side backs up only when every stage holds a word.
    `RDPA_ASSERT(a_stall_full, clk, rst_n, !in_stall || (out_valid && out_stall && r_valid && d_valid), "input stalled with an empty stage")
    // A word outside the image carries zero coordinates.
    `RDPA_ASSERT_NEVER(a_zero_outside, clk, rst_n, out_valid && !in_bounds && (src_x != '0 || src_y != '0), "nonzero coordinates outside the image")
    // A word inside the image lies below the image size.
    `RDPA_ASSERT(a_in_range, clk, rst_n, !(out_valid && in_bounds) || (32'(src_x) < SRC_WIDTH && 32'(src_y) < IMG_HEIGHT), "coordinate beyond the image size")

endmodule

`default_nettype wire

@@ sv/rdpa_cfg_regs.sv @@
// Configuration register file of the pixel address unit.
// Depends on rdpa_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module rdpa_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [rdpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rdpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rdpa_pkg::cfg_t                          cfg
);

    rdpa_pkg::cfg_t cfg_reg;
    rdpa_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            // Writes to an index beyond the register list are dropped.
            unique case (cfg_index)
                rdpa_pkg::REG_COS:
                    cfg_next.cos_q12 = signed'(cfg_data[rdpa_pkg::TRIG_W-1:0]);
                rdpa_pkg::REG_SIN:
                    cfg_next.sin_q12 = signed'(cfg_data[rdpa_pkg::TRIG_W-1:0]);
                rdpa_pkg::REG_SHIFT_X:
                    cfg_next.shift_x_q12 = signed'(cfg_data[rdpa_pkg::SHIFT_W-1:0]);
                rdpa_pkg::REG_SHIFT_Y:
                    cfg_next.shift_y_q12 = signed'(cfg_data[rdpa_pkg::SHIFT_W-1:0]);
                rdpa_pkg::REG_START_Y:
                    cfg_next.start_y_q8 = cfg_data[rdpa_pkg::START_W-1:0];
                rdpa_pkg::REG_ROW_STEP:
                    cfg_next.row_step_q8 = cfg_data[rdpa_pkg::STEP_W-1:0];
                rdpa_pkg::REG_COL_STEP:
                    cfg_next.col_step_q8 = cfg_data[rdpa_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_q12     <= rdpa_pkg::COS_RESET;
            cfg_reg.sin_q12     <= rdpa_pkg::SIN_RESET;
            cfg_reg.shift_x_q12 <= rdpa_pkg::SHIFT_X_RESET;
            cfg_reg.shift_y_q12 <= rdpa_pkg::SHIFT_Y_RESET;
            cfg_reg.start_y_q8  <= rdpa_pkg::START_Y_RESET;
            cfg_reg.row_step_q8 <= rdpa_pkg::ROW_STEP_RESET;
            cfg_reg.col_step_q8 <= rdpa_pkg::COL_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/rdpa_dst.sv @@
// First pipeline stage: destination position in Q8 and window range check.
// Depends on rdpa_pkg for widths and cfg_t.
`default_nettype none

module rdpa_dst #(
    parameter int ROW_COUNT = rdpa_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = rdpa_pkg::COL_COUNT_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [rdpa_pkg::ROW_W-1:0]             row,
    input  wire logic [rdpa_pkg::COL_W-1:0]             column,
    input  wire logic signed [rdpa_pkg::BASE_W-1:0]     digit_base_x_q8,
    input  wire rdpa_pkg::cfg_t                         cfg,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [rdpa_pkg::POS_W-1:0]           dst_x,
    output logic signed [rdpa_pkg::POS_W-1:0]           dst_y,
    output logic                                        win_ok
);

    localparam int ROW_PROD_W = rdpa_pkg::ROW_W + rdpa_pkg::STEP_W;
    localparam int COL_PROD_W = rdpa_pkg::COL_W + rdpa_pkg::STEP_W;
    localparam logic [rdpa_pkg::LIMIT_W-1:0] ROW_LIM = rdpa_pkg::LIMIT_W'(ROW_COUNT);
    localparam logic [rdpa_pkg::LIMIT_W-1:0] COL_LIM = rdpa_pkg::LIMIT_W'(COL_COUNT);

    logic                                   valid_reg;
    logic signed [rdpa_pkg::POS_W-1:0]      dst_x_reg;
    logic signed [rdpa_pkg::POS_W-1:0]      dst_y_reg;
    logic                                   win_ok_reg;
    logic signed [rdpa_pkg::POS_W-1:0]      dst_x_next;
    logic signed [rdpa_pkg::POS_W-1:0]      dst_y_next;
    logic                                   win_ok_next;
    logic [ROW_PROD_W-1:0]                  row_prod;
    logic [COL_PROD_W-1:0]                  col_prod;
    logic                                   advance;

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        row_prod    = ROW_PROD_W'(row) * ROW_PROD_W'(cfg.row_step_q8);
        col_prod    = COL_PROD_W'(column) * COL_PROD_W'(cfg.col_step_q8);
        dst_y_next  = $signed(rdpa_pkg::POS_W'(row_prod) + rdpa_pkg::POS_W'(cfg.start_y_q8));
        dst_x_next  = rdpa_pkg::POS_W'(digit_base_x_q8)
                    + $signed(rdpa_pkg::POS_W'(col_prod));
        win_ok_next = (rdpa_pkg::LIMIT_W'(row) < ROW_LIM)
                   && (rdpa_pkg::LIMIT_W'(column) < COL_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            dst_x_reg  <= dst_x_next;
            dst_y_reg  <= dst_y_next;
            win_ok_reg <= win_ok_next;
        end
    end

    assign out_valid = valid_reg;
    assign dst_x     = dst_x_reg;
    assign dst_y     = dst_y_reg;
    assign win_ok    = win_ok_reg;

endmodule

`default_nettype wire

@@ sv/rdpa_rotate.sv @@
// Second and third pipeline stages: Q20 rotation products, then the sums
// with the Q8 floor shift and the Q12 translation. Depends on rdpa_pkg.
`default_nettype none

module rdpa_rotate (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [rdpa_pkg::POS_W-1:0]      dst_x,
    input  wire logic signed [rdpa_pkg::POS_W-1:0]      dst_y,
    input  wire logic                                   win_ok,
    input  wire rdpa_pkg::cfg_t                         cfg,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [rdpa_pkg::ACC_W-1:0]           acc_x,
    output logic signed [rdpa_pkg::ACC_W-1:0]           acc_y,
    output logic                                        out_win_ok
);

    localparam int PROD_W = rdpa_pkg::PROD_W;
    localparam int SUM_W  = rdpa_pkg::SUM_W;
    localparam int ACC_W  = rdpa_pkg::ACC_W;

    // Product stage.
    logic                       p_valid_reg;
    logic signed [PROD_W-1:0]   xc_reg;
    logic signed [PROD_W-1:0]   ys_reg;
    logic signed [PROD_W-1:0]   yc_reg;
    logic signed [PROD_W-1:0]   xs_reg;
    logic                       p_win_reg;
    logic signed [PROD_W-1:0]   xc_next;
    logic signed [PROD_W-1:0]   ys_next;
    logic signed [PROD_W-1:0]   yc_next;
    logic signed [PROD_W-1:0]   xs_next;

    // Sum stage.
    logic                       s_valid_reg;
    logic signed [ACC_W-1:0]    acc_x_reg;
    logic signed [ACC_W-1:0]    acc_y_reg;
    logic                       s_win_reg;
    logic signed [SUM_W-1:0]    sum_x;
    logic signed [SUM_W-1:0]    sum_y;
    logic signed [ACC_W-1:0]    acc_x_next;
    logic signed [ACC_W-1:0]    acc_y_next;

    logic                       p_advance;
    logic                       s_advance;

    assign s_advance = !s_valid_reg || !out_stall;
    assign p_advance = !p_valid_reg || s_advance;
    assign in_stall  = !p_advance;

    always_comb
    begin
        xc_next = PROD_W'(dst_x) * PROD_W'(cfg.cos_q12);
        ys_next = PROD_W'(dst_y) * PROD_W'(cfg.sin_q12);
        yc_next = PROD_W'(dst_y) * PROD_W'(cfg.cos_q12);
        xs_next = PROD_W'(dst_x) * PROD_W'(cfg.sin_q12);
    end

    // The Q8 shift drops the sum to 31 significant bits, so the cast to the
    // accumulator width loses nothing before the translation is added.
    always_comb
    begin
        sum_x      = SUM_W'(xc_reg) + SUM_W'(ys_reg);
        sum_y      = SUM_W'(yc_reg) - SUM_W'(xs_reg);
        acc_x_next = ACC_W'(sum_x >>> rdpa_pkg::POS_FRAC) + ACC_W'(cfg.shift_x_q12);
        acc_y_next = ACC_W'(sum_y >>> rdpa_pkg::POS_FRAC) + ACC_W'(cfg.shift_y_q12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_advance)
            begin
                p_valid_reg <= in_valid;
            end
            if (s_advance)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_advance && in_valid)
        begin
            xc_reg    <= xc_next;
            ys_reg    <= ys_next;
            yc_reg    <= yc_next;
            xs_reg    <= xs_next;
            p_win_reg <= win_ok;
        end
        if (s_advance && p_valid_reg)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            s_win_reg <= p_win_reg;
        end
    end

    assign out_valid  = s_valid_reg;
    assign acc_x      = acc_x_reg;
    assign acc_y      = acc_y_reg;
    assign out_win_ok = s_win_reg;

endmodule

`default_nettype wire

@@ sv/rdpa_bound.sv @@
// Last pipeline stage: Q12 floor shift, image bounds check and the output
// register. Depends on rdpa_pkg for widths.
`default_nettype none

module rdpa_bound #(
    parameter int SRC_WIDTH  = rdpa_pkg::SRC_WIDTH_DEF,
    parameter int IMG_HEIGHT = rdpa_pkg::IMG_HEIGHT_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [rdpa_pkg::ACC_W-1:0]      acc_x,
    input  wire logic signed [rdpa_pkg::ACC_W-1:0]      acc_y,
    input  wire logic                                   win_ok,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [rdpa_pkg::SRC_X_W-1:0]                src_x,
    output logic [rdpa_pkg::SRC_Y_W-1:0]                src_y,
    output logic                                        in_bounds
);

    localparam int COORD_W = rdpa_pkg::COORD_W;
    localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(SRC_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(IMG_HEIGHT);

    logic                                   valid_reg;
    logic [rdpa_pkg::SRC_X_W-1:0]           src_x_reg;
    logic [rdpa_pkg::SRC_Y_W-1:0]           src_y_reg;
    logic                                   in_bounds_reg;
    logic [rdpa_pkg::SRC_X_W-1:0]           src_x_next;
    logic [rdpa_pkg::SRC_Y_W-1:0]           src_y_next;
    logic                                   in_bounds_next;
    logic signed [COORD_W-1:0]              coord_x;
    logic signed [COORD_W-1:0]              coord_y;
    logic                                   advance;

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        coord_x        = COORD_W'(acc_x >>> rdpa_pkg::TRIG_FRAC);
        coord_y        = COORD_W'(acc_y >>> rdpa_pkg::TRIG_FRAC);
        in_bounds_next = win_ok
                      && !coord_x[COORD_W-1] && (coord_x < X_LIM)
                      && !coord_y[COORD_W-1] && (coord_y < Y_LIM);
        if (in_bounds_next)
        begin
            src_x_next = coord_x[rdpa_pkg::SRC_X_W-1:0];
            src_y_next = coord_y[rdpa_pkg::SRC_Y_W-1:0];
        end
        else
        begin
            src_x_next = '0;
            src_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            src_x_reg     <= src_x_next;
            src_y_reg     <= src_y_next;
            in_bounds_reg <= in_bounds_next;
        end
    end

    assign out_valid = valid_reg;
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;
    assign in_bounds = in_bounds_reg;

endmodule

`default_nettype wire

@@ test/rdpa_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the rotated digit pixel address unit: follows register writes,
// predicts the source address of every accepted pixel word and checks outputs.
// Depends on rdpa_pkg for widths, register codes, reset values and cfg_t.

module rdpa_checker
    import rdpa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [ROW_W-1:0]          row,
    input  logic [COL_W-1:0]          column,
    input  logic signed [BASE_W-1:0]  digit_base_x_q8,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [SRC_X_W-1:0]        src_x,
    input  logic [SRC_Y_W-1:0]        src_y,
    input  logic                      in_bounds,
    output int                        fail_count,
    output int                        pending_words,
    output int                        words_checked,
    output int                        words_inside
);

    typedef struct packed {
        logic [SRC_X_W-1:0] src_x;
        logic [SRC_Y_W-1:0] src_y;
        logic               in_bounds;
    } src_addr_t;

    cfg_t      rot_cfg;
    src_addr_t expected_addrs[$];
    int        errs;
    int        checked;
    int        in_image;

    // Destination position in Q8, rotated with Q12 trig; every shift floors.
    function automatic src_addr_t predict_src_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic signed [BASE_W-1:0] b);
        longint    dst_x;
        longint    dst_y;
        longint    cs;
        longint    sn;
        longint    sx;
        longint    sy;
        src_addr_t a;
        cs    = longint'($signed(rot_cfg.cos_q12));
        sn    = longint'($signed(rot_cfg.sin_q12));
        dst_y = longint'(r) * longint'(rot_cfg.row_step_q8) + longint'(rot_cfg.start_y_q8);
        dst_x = longint'(b) + longint'(c) * longint'(rot_cfg.col_step_q8);
        sx = ((dst_x * cs + dst_y * sn) >>> POS_FRAC)
             + longint'($signed(rot_cfg.shift_x_q12));
        sx = sx >>> TRIG_FRAC;
        sy = ((dst_y * cs - dst_x * sn) >>> POS_FRAC)
             + longint'($signed(rot_cfg.shift_y_q12));
        sy = sy >>> TRIG_FRAC;
        a = '0;
        if (r < ROW_COUNT_DEF && c < COL_COUNT_DEF && sx >= 0 && sx < SRC_WIDTH_DEF
            && sy >= 0 && sy < IMG_HEIGHT_DEF)
        begin
            a.src_x     = sx[SRC_X_W-1:0];
            a.src_y     = sy[SRC_Y_W-1:0];
            a.in_bounds = 1'b1;
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        src_addr_t want;
        src_addr_t got;
        if (!rst_n)
        begin
            rot_cfg.cos_q12     = COS_RESET;
            rot_cfg.sin_q12     = SIN_RESET;
            rot_cfg.shift_x_q12 = SHIFT_X_RESET;
            rot_cfg.shift_y_q12 = SHIFT_Y_RESET;
            rot_cfg.start_y_q8  = START_Y_RESET;
            rot_cfg.row_step_q8 = ROW_STEP_RESET;
            rot_cfg.col_step_q8 = COL_STEP_RESET;
            expected_addrs.delete();
            errs     = 0;
            checked  = 0;
            in_image = 0;
            fail_count    <= 0;
            pending_words <= 0;
            words_checked <= 0;
            words_inside  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_addrs.push_back(predict_src_addr(row, column, digit_base_x_q8));
            if (out_valid && !out_stall)
            begin
                got.src_x     = src_x;
                got.src_y     = src_y;
                got.in_bounds = in_bounds;
                checked++;
                if (in_bounds === 1'b1)
                    in_image++;
                if (expected_addrs.size() == 0)
                begin
                    $display("%0t: output word with none expected: src_x %0d src_y %0d in_bounds %0b",
                             $time, got.src_x, got.src_y, got.in_bounds);
                    errs++;
                end
                else
                begin
                    want = expected_addrs.pop_front();
                    if (got.src_x !== want.src_x)
                    begin
                        $display("%0t: src_x expected %0d, got %0d", $time, want.src_x, got.src_x);
                        errs++;
                    end
                    if (got.src_y !== want.src_y)
                    begin
                        $display("%0t: src_y expected %0d, got %0d", $time, want.src_y, got.src_y);
                        errs++;
                    end
                    if (got.in_bounds !== want.in_bounds)
                    begin
                        $display("%0t: in_bounds expected %0b, got %0b",
                                 $time, want.in_bounds, got.in_bounds);
                        errs++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COS:      rot_cfg.cos_q12     = cfg_data[TRIG_W-1:0];
                    REG_SIN:      rot_cfg.sin_q12     = cfg_data[TRIG_W-1:0];
                    REG_SHIFT_X:  rot_cfg.shift_x_q12 = cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_Y:  rot_cfg.shift_y_q12 = cfg_data[SHIFT_W-1:0];
                    REG_START_Y:  rot_cfg.start_y_q8  = cfg_data[START_W-1:0];
                    REG_ROW_STEP: rot_cfg.row_step_q8 = cfg_data[STEP_W-1:0];
                    REG_COL_STEP: rot_cfg.col_step_q8 = cfg_data[STEP_W-1:0];
                    default:      ;
                endcase
            end
            fail_count    <= errs;
            pending_words <= expected_addrs.size();
            words_checked <= checked;
            words_inside  <= in_image;
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the pixel address unit testbench: clock, reset, register settings,
// pixel word stimulus, output stalls and the verdict.
// Depends on rdpa_pkg, the unit itself and rdpa_checker.

module tb;
    import rdpa_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PHASE_WORDS     = 50;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRESSURE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 8;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [BASE_W-1:0] digit_base_x_q8;
    logic                     out_valid;
    logic                     out_stall;
    logic [SRC_X_W-1:0]       src_x;
    logic [SRC_Y_W-1:0]       src_y;
    logic                     in_bounds;

    int chk_failures;
    int chk_pending;
    int chk_words;
    int chk_inside;
    int settings_used = 1;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit send_steady = 1'b0;
    bit hold_req = 1'b0;
    bit hold_on = 1'b0;

    rotated_digit_pixel_address_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .row             (row),
        .column          (column),
        .digit_base_x_q8 (digit_base_x_q8),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .src_x           (src_x),
        .src_y           (src_y),
        .in_bounds       (in_bounds)
    );

    rdpa_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .row             (row),
        .column          (column),
        .digit_base_x_q8 (digit_base_x_q8),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .src_x           (src_x),
        .src_y           (src_y),
        .in_bounds       (in_bounds),
        .fail_count      (chk_failures),
        .pending_words   (chk_pending),
        .words_checked   (chk_words),
        .words_inside    (chk_inside)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Fills the bits above a narrow register with noise; the unit must ignore them.
    function automatic int with_junk(input int v, input int w);
        return (int'($urandom) << w) | (v & ((1 << w) - 1));
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic write_settings(input int cs, input int sn, input int sx, input int sy,
                                  input int sty, input int rs, input int cstep);
        write_reg(REG_COS, cs);
        write_reg(REG_SIN, sn);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_START_Y, sty);
        write_reg(REG_ROW_STEP, rs);
        write_reg(REG_COL_STEP, cstep);
        write_reg(REG_UNUSED, int'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic pick_settings(input bit wide);
        if (wide)
            write_settings(with_junk(int'($urandom_range(0, 8192)) - 4096, TRIG_W),
                           with_junk(int'($urandom_range(0, 8192)) - 4096, TRIG_W),
                           int'($urandom), int'($urandom),
                           with_junk(int'($urandom), START_W),
                           with_junk(int'($urandom), STEP_W),
                           with_junk(int'($urandom), STEP_W));
        else
            write_settings(4096 - int'($urandom_range(0, 120)),
                           int'($urandom_range(0, 1600)) - 800,
                           (int'($urandom_range(0, 120)) - 60) * 4096 + 2048,
                           (int'($urandom_range(0, 300)) - 60) * 4096 + 2048,
                           $urandom_range(0, 300 * 256),
                           $urandom_range(128, 1024),
                           $urandom_range(128, 1024));
    endtask

    task automatic send_pixel(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                              input int b);
        int gap;
        gap = (quiet || send_steady) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        row             <= r;
        column          <= c;
        digit_base_x_q8 <= b[BASE_W-1:0];
        do @(posedge clk); while (in_stall);
    endtask

    // Lets every expected word come back before the registers change.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // Mostly scan lines across one digit row, the rest isolated words anywhere.
    task automatic run_phase(input int words);
        int done_words;
        int r;
        int c;
        int len;
        int b;
        done_words = 0;
        while (done_words < words)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r   = $urandom_range(0, 63);
                c   = $urandom_range(0, 31);
                len = $urandom_range(4, 16);
                b   = int'($urandom_range(0, 720 * 256)) - 40 * 256;
                while (len > 0 && c < COL_COUNT_DEF && done_words < words)
                begin
                    send_pixel(r[ROW_W-1:0], c[COL_W-1:0], b);
                    c++;
                    len--;
                    done_words++;
                end
            end
            else
            begin
                b = int'($urandom_range(0, 524287)) - 262144;
                send_pixel(ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 31)), b);
                done_words++;
            end
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= REG_COS;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        row             <= '0;
        column          <= '0;
        digit_base_x_q8 <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity rotation after reset: corners, field extremes, the right
        // image edge and a position just left of zero that must floor to -1.
        send_pixel(0, 0, 0);
        send_pixel(63, 31, 262143);
        send_pixel(63, 0, -262144);
        send_pixel(12, 7, 100 * 256);
        send_pixel(0, 31, 608 * 256);
        send_pixel(0, 31, 609 * 256);
        send_pixel(5, 0, -1);

        drain();
        write_settings(-4096, 4096, -8388608, 8388607, 262143, 65535, 65535);
        send_pixel(63, 31, 262143);
        send_pixel(0, 0, -262144);
        send_pixel(63, 0, 0);
        send_pixel(0, 31, -262144);

        drain();
        write_settings(4096, -4096, 8388607, -8388608, 0, 0, 0);
        send_pixel(0, 0, 0);
        send_pixel(63, 31, -262144);
        send_pixel(32, 16, 262143);

        // Modest deskew near the bottom of the image so rows run off the end.
        drain();
        write_settings(4000, 880, 50 * 4096 + 2048, 2048, 420 * 256, 300, 200);
        send_pixel(0, 0, 100 * 256);
        send_pixel(63, 31, 500 * 256);
        send_pixel(40, 10, -5 * 256);
        send_pixel(0, 20, 300 * 256);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            quiet       = (p == 2);
            send_steady = (p == 4);
            pick_settings(p == 5);
            if (p == 4)
            begin
                hold_req = 1'b1;
                while (!hold_on)
                    @(posedge clk);
            end
            run_phase(PHASE_WORDS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d pixel words under %0d register settings, %0d inside the image.",
                 chk_words, settings_used, chk_inside);
        $display("The output side held off once for %0d cycles with the input backed up.",
                 PRESSURE_CYCLES);
        if (chk_failures == 0 && chk_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_on)
            begin
                hold_on = 1'b1;
                out_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (1 + pick_gap()) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (quiet ? 8 : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

endmodule
